>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers, included by ukf_ring
// Each macro expects clk_i and rst_ni in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define UKF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define UKF_ASSERT_NEVER(label, expr, msg) \
  `UKF_ASSERT(label, !(expr), msg)

`endif

>>> hw/rtl/ukf_pkg.sv
// ----------------------------------------------------------------------------
// ukf_pkg: shared types and constants of the unique key queue
// Command and status codes, field widths and the request and response
// structs passed between the top level and the ring store.
// ----------------------------------------------------------------------------
package ukf_pkg;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned OccW   = 5;
  localparam int unsigned StatW  = 3;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_ENQUEUED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_DEQUEUED  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef struct packed {
    logic              valid;
    cmd_e              cmd;
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
  } ukf_req_t;

  typedef struct packed {
    status_e           status;
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
  } ukf_rsp_t;

endpackage

>>> hw/rtl/ukf_ring.sv
// ----------------------------------------------------------------------------
// ukf_ring: ring store of key and value entries with duplicate detection
// Compares the request key against every occupied slot in parallel, decides
// the operation and updates head, tail, count and slot valid bits.
// ----------------------------------------------------------------------------
module ukf_ring #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ukf_pkg::ukf_req_t                  req_i,
  output ukf_pkg::ukf_rsp_t                  rsp_o,
  output logic [$clog2(DEPTH+1)-1:0]         count_o,
  output logic                               empty_o
);
  import ukf_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [KeyW-1:0]   key_q   [DEPTH];
  logic [ValueW-1:0] value_q [DEPTH];
  logic [DEPTH-1:0]  occ_q;
  logic [IdxW-1:0]   head_q, tail_q, head_inc, tail_inc;
  logic [CntW-1:0]   count_q, count_d;
  logic [DEPTH-1:0]  hit;
  logic              dup, full, empty, do_enq, do_deq;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = occ_q[i] && (key_q[i] == req_i.key);
    end
  end

  assign dup   = |hit;
  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  assign head_inc = (head_q == IdxW'(DEPTH - 1)) ? '0 : head_q + IdxW'(1);
  assign tail_inc = (tail_q == IdxW'(DEPTH - 1)) ? '0 : tail_q + IdxW'(1);

  // Duplicate check wins over full.
  assign do_enq = req_i.valid && (req_i.cmd == CMD_ENQ) && !dup && !full;
  assign do_deq = req_i.valid && (req_i.cmd == CMD_DEQ) && !empty;

  always_comb begin
    rsp_o.key   = '0;
    rsp_o.value = '0;
    case (req_i.cmd)
      CMD_ENQ: begin
        if (dup) begin
          rsp_o.status = ST_DUPLICATE;
        end else if (full) begin
          rsp_o.status = ST_FULL;
        end else begin
          rsp_o.status = ST_ENQUEUED;
        end
      end
      CMD_DEQ: begin
        if (empty) begin
          rsp_o.status = ST_UNDERFLOW;
        end else begin
          rsp_o.status = ST_DEQUEUED;
          rsp_o.key    = key_q[head_q];
          rsp_o.value  = value_q[head_q];
        end
      end
      default: begin
        rsp_o.status = ST_UNDERFLOW;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_enq) begin
      count_d = count_q + CntW'(1);
    end else if (do_deq) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign count_o = count_d;
  assign empty_o = (count_d == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      occ_q   <= '0;
    end else begin
      count_q <= count_d;
      if (do_enq) begin
        occ_q[tail_q] <= 1'b1;
        tail_q        <= tail_inc;
      end
      if (do_deq) begin
        occ_q[head_q] <= 1'b0;
        head_q        <= head_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      key_q[tail_q]   <= req_i.key;
      value_q[tail_q] <= req_i.value;
    end
  end

`include "assert_macros.svh"

  `UKF_ASSERT(a_count_matches_valid, CntW'($countones(occ_q)) == count_q, "count mismatch")
  `UKF_ASSERT(a_keys_unique, $onehot0(hit), "key stored in more than one slot")
  `UKF_ASSERT_NEVER(a_enq_overwrite, do_enq && occ_q[tail_q], "enqueue into an occupied slot")

endmodule

>>> hw/rtl/unique_key_fifo.sv
// ----------------------------------------------------------------------------
// unique_key_fifo: FIFO of key and value entries that rejects duplicate keys
// Each input word is an enqueue (tuser 0) or a dequeue (tuser 1) and yields
// exactly one result word: a status, the dequeued entry, the entry count
// and an empty flag. One word is accepted every clock cycle while the
// output is not stalled; a result word passes through the input register,
// then the result register, before it is presented. The new key is
// compared combinationally against all DEPTH slot registers in parallel.
// Output stalls hold the result register and back up into the input
// register.
// ----------------------------------------------------------------------------
module unique_key_fifo #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] entry_key, [47:16] entry_value
  input  logic [47:0] s_axis_tdata_i,
  // [0] command
  input  logic [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] removed_key, [47:16] removed_value, [52:48] occupancy,
  // [53] empty_flag, [55:54] zero
  output logic [55:0] m_axis_tdata_o,
  // [2:0] status
  output logic [2:0]  m_axis_tuser_o
);
  import ukf_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic              in_vld_q;
  cmd_e              in_cmd_q;
  logic [KeyW-1:0]   in_key_q;
  logic [ValueW-1:0] in_val_q;

  logic              out_vld_q;
  status_e           out_status_q;
  logic [KeyW-1:0]   out_key_q;
  logic [ValueW-1:0] out_val_q;
  logic [OccW-1:0]   out_occ_q;
  logic              out_empty_q;

  logic                 advance, in_take;
  ukf_req_t             req;
  ukf_rsp_t             rsp;
  logic [CntW-1:0]      cnt;
  logic                 empty;
  logic [OccW+CntW-1:0] cnt_ext;

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  assign req.valid = advance;
  assign req.cmd   = in_cmd_q;
  assign req.key   = in_key_q;
  assign req.value = in_val_q;

  ukf_ring #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .count_o (cnt),
    .empty_o (empty)
  );

  // Occupancy field keeps the low bits of the count.
  assign cnt_ext = {{OccW{1'b0}}, cnt};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q <= cmd_e'(s_axis_tuser_i);
      in_key_q <= s_axis_tdata_i[KeyW-1:0];
      in_val_q <= s_axis_tdata_i[KeyW+ValueW-1:KeyW];
    end
    if (advance) begin
      out_status_q <= rsp.status;
      out_key_q    <= rsp.key;
      out_val_q    <= rsp.value;
      out_occ_q    <= cnt_ext[OccW-1:0];
      out_empty_q  <= empty;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {2'b00, out_empty_q, out_occ_q, out_val_q, out_key_q};

endmodule
